// ===== rtl/tlbw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlbw_pkg
// Shared types and constants for the timed latching push button.
// ----------------------------------------------------------------------------
package tlbw_pkg;

  // Register indexes, taken from paddr[4:2].
  localparam logic [2:0] REG_PULLED_UP      = 3'd0;
  localparam logic [2:0] REG_NORMALLY_OPEN  = 3'd1;
  localparam logic [2:0] REG_DEBOUNCE_MS    = 3'd2;
  localparam logic [2:0] REG_START_DELAY_MS = 3'd3;
  localparam logic [2:0] REG_SERVICE_MS     = 3'd4;
  localparam logic [2:0] REG_WARNING_PCT    = 3'd5;
  localparam logic [2:0] REG_RETRIGGERABLE  = 3'd6;
  localparam logic [2:0] REG_KEEP_PILOT     = 3'd7;

  // Saturation limits and the percent ceiling.
  localparam logic [16:0] PRESS_MAX   = 17'h1FFFF;
  localparam logic [23:0] SERVICE_MAX = 24'hFFFFFF;
  localparam logic [6:0]  PCT_MAX     = 7'd100;

  // Effective configuration as seen by the step logic.
  typedef struct packed {
    logic        pulled_up;
    logic        normally_open;
    logic [15:0] debounce_eff;
    logic [15:0] start_delay;
    logic [23:0] service_eff;
    logic        warn_en;
    logic [30:0] warn_prod;   // service_eff * clamped percent
    logic        retriggerable;
    logic        keep_pilot;
  } cfg_t;

  // One result word; is_on sits in the lowest bit.
  typedef struct packed {
    logic outputs_changed;
    logic is_pressed;
    logic pilot_on;
    logic warning_on;
    logic is_on;
  } res_t;

endpackage
`default_nettype wire

// ===== rtl/timed_latch_button_with_warning.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// timed_latch_button_with_warning
// Debounced, timed latching push button with warning and pilot flags.
// ----------------------------------------------------------------------------
// Each input word is one millisecond tick carrying the raw pin level, and
// each tick yields exactly one result word. A tick is taken every clock
// cycle while s_tready is high: the whole step is one pass of counter and
// compare logic that updates the state registers and loads the result into
// the output register, or into the skid stage if a result still waits there,
// at the edge the word is accepted. The skid stage lets one more tick in
// while a result waits; s_tready drops only when both are full. Configuration
// should be written while no results are outstanding.
module timed_latch_button_with_warning #(
  parameter int MIN_DEBOUNCE_MS = 20,
  parameter int MIN_SERVICE_MS  = 1000
) (
  input  wire         clk,
  input  wire         rst,
  // Tick input
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [7:0]  s_tdata,   // [0] pin_level
  // Result output
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [7:0]  m_tdata,   // [0] is_on, [1] warning_on, [2] pilot_on,
                                 // [3] is_pressed, [4] outputs_changed
  // Configuration port
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [4:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tlbw_pkg::*;

  cfg_t cfg;
  res_t res;
  logic step;

  assign step = s_tvalid & s_tready;

  tlbw_cfg #(
    .MIN_DEBOUNCE_MS (MIN_DEBOUNCE_MS),
    .MIN_SERVICE_MS  (MIN_SERVICE_MS)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tlbw_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .step      (step),
    .pin_level (s_tdata[0]),
    .res       (res)
  );

  tlbw_obuf u_obuf (
    .clk      (clk),
    .rst      (rst),
    .in_valid (step),
    .in_res   (res),
    .in_ready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
`default_nettype wire

// ===== rtl/tlbw_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlbw_cfg
// Configuration register file on an APB-style port. Also keeps the product
// of the effective service time and the clamped warning percent, updated by
// the write that changes either operand.
// ----------------------------------------------------------------------------
module tlbw_cfg #(
  parameter int MIN_DEBOUNCE_MS = 20,
  parameter int MIN_SERVICE_MS  = 1000
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 psel,
  input  wire                 penable,
  input  wire                 pwrite,
  input  wire  [4:0]          paddr,
  input  wire  [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output tlbw_pkg::cfg_t      cfg
);
  import tlbw_pkg::*;

  localparam logic [15:0] MinDeb = 16'(MIN_DEBOUNCE_MS);
  localparam logic [23:0] MinSrv = 24'(MIN_SERVICE_MS);

  logic        pulled_up;
  logic        normally_open;
  logic [15:0] debounce_ms;
  logic [15:0] start_delay_ms;
  logic [23:0] service_ms;
  logic [6:0]  warning_percent;
  logic        retriggerable;
  logic        keep_pilot;
  logic [30:0] warn_prod;

  logic        wr_en;
  logic [2:0]  wr_idx;
  logic [23:0] srv_eff;
  logic [6:0]  pct_eff;
  logic [23:0] wr_srv_eff;
  logic [6:0]  wr_pct_eff;
  logic [23:0] mul_a;
  logic [6:0]  mul_b;
  logic [30:0] warn_prod_next;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign wr_idx = paddr[4:2];

  // Effective values of the stored registers and of the word being written.
  assign srv_eff    = (service_ms < MinSrv) ? MinSrv : service_ms;
  assign pct_eff    = (warning_percent > PCT_MAX) ? PCT_MAX : warning_percent;
  assign wr_srv_eff = (pwdata[23:0] < MinSrv) ? MinSrv : pwdata[23:0];
  assign wr_pct_eff = (pwdata[6:0] > PCT_MAX) ? PCT_MAX : pwdata[6:0];

  // The write that changes an operand supplies it directly to the multiplier.
  assign mul_a = (wr_idx == REG_SERVICE_MS) ? wr_srv_eff : srv_eff;
  assign mul_b = (wr_idx == REG_WARNING_PCT) ? wr_pct_eff : pct_eff;
  assign warn_prod_next = 31'(mul_a) * 31'(mul_b);

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      pulled_up       <= 1'b1;
      normally_open   <= 1'b1;
      debounce_ms     <= 16'd20;
      start_delay_ms  <= 16'd0;
      service_ms      <= 24'd1000;
      warning_percent <= 7'd0;
      retriggerable   <= 1'b0;
      keep_pilot      <= 1'b0;
      warn_prod       <= '0;
    end else if (wr_en) begin
      case (wr_idx)
        REG_PULLED_UP:      pulled_up       <= pwdata[0];
        REG_NORMALLY_OPEN:  normally_open   <= pwdata[0];
        REG_DEBOUNCE_MS:    debounce_ms     <= pwdata[15:0];
        REG_START_DELAY_MS: start_delay_ms  <= pwdata[15:0];
        REG_SERVICE_MS: begin
          service_ms <= pwdata[23:0];
          warn_prod  <= warn_prod_next;
        end
        REG_WARNING_PCT: begin
          warning_percent <= pwdata[6:0];
          warn_prod       <= warn_prod_next;
        end
        REG_RETRIGGERABLE:  retriggerable   <= pwdata[0];
        REG_KEEP_PILOT:     keep_pilot      <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    case (wr_idx)
      REG_PULLED_UP:      prdata = {31'd0, pulled_up};
      REG_NORMALLY_OPEN:  prdata = {31'd0, normally_open};
      REG_DEBOUNCE_MS:    prdata = {16'd0, debounce_ms};
      REG_START_DELAY_MS: prdata = {16'd0, start_delay_ms};
      REG_SERVICE_MS:     prdata = {8'd0, service_ms};
      REG_WARNING_PCT:    prdata = {25'd0, warning_percent};
      REG_RETRIGGERABLE:  prdata = {31'd0, retriggerable};
      REG_KEEP_PILOT:     prdata = {31'd0, keep_pilot};
      default:            prdata = 32'd0;
    endcase
  end

  // Effective configuration for the step logic.
  always_comb begin
    cfg.pulled_up     = pulled_up;
    cfg.normally_open = normally_open;
    cfg.debounce_eff  = (debounce_ms < MinDeb) ? MinDeb : debounce_ms;
    cfg.start_delay   = start_delay_ms;
    cfg.service_eff   = srv_eff;
    cfg.warn_en       = (warning_percent != 7'd0);
    cfg.warn_prod     = warn_prod;
    cfg.retriggerable = retriggerable;
    cfg.keep_pilot    = keep_pilot;
  end

endmodule
`default_nettype wire

// ===== rtl/tlbw_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlbw_core
// Per-tick step: polarity conversion, press timing, service timer, output
// latch, warning and pilot flags. State advances on every accepted tick.
// ----------------------------------------------------------------------------
module tlbw_core (
  input  wire                 clk,
  input  wire                 rst,
  input  tlbw_pkg::cfg_t      cfg,
  input  wire                 step,
  input  wire                 pin_level,
  output tlbw_pkg::res_t      res
);
  import tlbw_pkg::*;

  // State registers.
  logic        press_timing;
  logic        release_wait;
  logic [16:0] press_counter;
  logic        unlatch_wait;
  logic        output_on;
  logic [23:0] service_counter;
  logic        warning_flag;
  logic        pilot_flag;

  logic        press_timing_next;
  logic        release_wait_next;
  logic [16:0] press_counter_next;
  logic        unlatch_wait_next;
  logic        output_on_next;
  logic [23:0] service_counter_next;
  logic        warning_flag_next;
  logic        pilot_flag_next;

  logic        pressed;
  logic        press_hit;
  logic        expire;
  logic        valid_press;
  logic        unlatch_pend;
  logic        changed;
  logic        warn_now;
  logic        pilot_now;
  logic [16:0] press_thresh;
  logic [23:0] remain;
  logic [30:0] remain_ext;
  logic [30:0] remain_x100;

  assign press_thresh = 17'(cfg.debounce_eff) + 17'(cfg.start_delay);
  assign pressed      = ~(pin_level ^ cfg.pulled_up ^ cfg.normally_open);

  always_comb begin
    press_timing_next    = press_timing;
    release_wait_next    = release_wait;
    press_counter_next   = press_counter;
    service_counter_next = service_counter;
    output_on_next       = output_on;
    press_hit            = 1'b0;
    expire               = 1'b0;
    changed              = 1'b0;
    warn_now             = 1'b0;

    // Press timing: one valid press per press.
    if (pressed) begin
      if (!release_wait) begin
        if (!press_timing) begin
          press_timing_next  = 1'b1;
          press_counter_next = '0;
        end else begin
          press_counter_next = (press_counter == PRESS_MAX) ? press_counter
                                                            : press_counter + 17'd1;
          if (press_counter_next >= press_thresh) begin
            press_hit         = 1'b1;
            release_wait_next = 1'b1;
          end
        end
      end
    end else begin
      press_timing_next  = 1'b0;
      press_counter_next = '0;
      release_wait_next  = 1'b0;
    end

    // Service timer; expiry cancels a press given on the same tick.
    if (output_on) begin
      service_counter_next = (service_counter == SERVICE_MAX) ? service_counter
                                                              : service_counter + 24'd1;
      if (service_counter_next >= cfg.service_eff) begin
        expire = 1'b1;
      end
    end
    valid_press       = press_hit & ~expire;
    unlatch_pend      = unlatch_wait | expire;
    unlatch_wait_next = unlatch_pend;

    // Output latch.
    if (valid_press) begin
      if (!output_on) begin
        service_counter_next = '0;
        output_on_next       = 1'b1;
        changed              = 1'b1;
      end else if (cfg.retriggerable) begin
        service_counter_next = '0;
      end
    end else if (unlatch_pend && output_on) begin
      output_on_next    = 1'b0;
      unlatch_wait_next = 1'b0;
      changed           = 1'b1;
    end

    // Remaining service time times 100, compared to service * percent below.
    remain      = cfg.service_eff - service_counter_next;
    remain_ext  = 31'(remain);
    remain_x100 = (remain_ext << 6) + (remain_ext << 5) + (remain_ext << 2);

    // Warning flag holds its value while the warning is disabled.
    warning_flag_next = warning_flag;
    if (cfg.warn_en) begin
      warn_now = output_on_next &&
                 ((service_counter_next >= cfg.service_eff) ||
                  (remain_x100 <= cfg.warn_prod));
      if (warn_now != warning_flag) begin
        changed = 1'b1;
      end
      warning_flag_next = warn_now;
    end

    // Pilot flag.
    pilot_now       = cfg.keep_pilot & ~output_on_next;
    pilot_flag_next = pilot_now;
    if (pilot_now != pilot_flag) begin
      changed = 1'b1;
    end

    res.is_on           = output_on_next;
    res.warning_on      = warning_flag_next;
    res.pilot_on        = pilot_flag_next;
    res.is_pressed      = pressed;
    res.outputs_changed = changed;
  end

  // State update on each accepted tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      press_timing    <= 1'b0;
      release_wait    <= 1'b0;
      press_counter   <= '0;
      unlatch_wait    <= 1'b0;
      output_on       <= 1'b0;
      service_counter <= '0;
      warning_flag    <= 1'b0;
      pilot_flag      <= 1'b0;
    end else if (step) begin
      press_timing    <= press_timing_next;
      release_wait    <= release_wait_next;
      press_counter   <= press_counter_next;
      unlatch_wait    <= unlatch_wait_next;
      output_on       <= output_on_next;
      service_counter <= service_counter_next;
      warning_flag    <= warning_flag_next;
      pilot_flag      <= pilot_flag_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tlbw_obuf.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlbw_obuf
// Output register with a skid stage, so a result word can be taken in while
// the previous one still waits on the master side.
// ----------------------------------------------------------------------------
module tlbw_obuf (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  input  tlbw_pkg::res_t      in_res,
  output logic                in_ready,
  output logic                m_tvalid,
  input  wire                 m_tready,
  output logic [7:0]          m_tdata
);
  import tlbw_pkg::*;

  res_t main_res;
  res_t skid_res;
  logic skid_valid;
  logic pop;

  assign in_ready = ~skid_valid;
  assign pop      = m_tvalid & m_tready;
  assign m_tdata  = {3'd0, main_res};

  // Control: main stage valid and skid stage valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (in_valid) begin
      if (!m_tvalid || pop) begin
        m_tvalid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload moves without reset.
  always_ff @(posedge clk) begin
    if (in_valid) begin
      if (!m_tvalid || pop) begin
        main_res <= in_res;
      end else begin
        skid_res <= in_res;
      end
    end else if (pop && skid_valid) begin
      main_res <= skid_res;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tlbw_check.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlbw_check
// Port-level checks for the timed latching push button, bound to the top.
// ----------------------------------------------------------------------------
module tlbw_check (
  input wire        clk,
  input wire        rst,
  input wire        s_tvalid,
  input wire        s_tready,
  input wire        m_tvalid,
  input wire        m_tready,
  input wire [7:0]  m_tdata
);

  // The input side stalls only after the output side stalled a word.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> $past(m_tvalid && !m_tready))
    else $error("input stalled without an output stall");

  // Every accepted tick leaves a result word waiting next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> m_tvalid)
    else $error("accepted tick produced no result word");

  // A stalled result word holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result word changed");

  // The pilot flag is never lit while the output is on.
  a_pilot_off: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[2]))
    else $error("pilot flag lit while output on");

endmodule

bind timed_latch_button_with_warning tlbw_check u_tlbw_check (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire

// ===== test/tb_timed_latch_button_with_warning.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_timed_latch_button_with_warning
// Self-checking testbench for the timed latching push button.
// ----------------------------------------------------------------------------
// Ticks carrying a pin level are streamed into the block with random gaps.
// A scoreboard tracks its own copy of the press timer, the service timer and
// the flags, and it compares every result word with the oldest expected one.
// Register settings are changed between phases while no result is pending.
// Each phase mixes clean press and release sequences with contact bounce.
// ----------------------------------------------------------------------------

import tlbw_pkg::*;

// Scoreboard: mirrors the button state and holds the expected result words.
class button_scoreboard;
  int        min_debounce;
  int        min_service;

  // Register copies.
  bit        pulled_up;
  bit        normally_open;
  bit [15:0] debounce_ms;
  bit [15:0] start_delay_ms;
  bit [23:0] service_ms;
  bit [6:0]  warning_pct;
  bit        retriggerable;
  bit        keep_pilot;

  // Button and timer state.
  bit        pressed_flag;
  bit        press_timing;
  bit        release_wait;
  bit        valid_press;
  bit        unlatch_wait;
  bit        output_on;
  bit        warning_flag;
  bit        pilot_flag;
  bit [16:0] press_count;
  bit [23:0] service_count;

  res_t      result_q[$];
  int        mismatches;
  int        results_seen;
  int        switch_ons;
  int        expiries;
  int        warning_rises;

  function new(int min_debounce_ms, int min_service_ms);
    min_debounce   = min_debounce_ms;
    min_service    = min_service_ms;
    pulled_up      = 1'b1;
    normally_open  = 1'b1;
    debounce_ms    = 16'd20;
    start_delay_ms = 16'd0;
    service_ms     = 24'd1000;
    warning_pct    = 7'd0;
    retriggerable  = 1'b0;
    keep_pilot     = 1'b0;
  endfunction

  // Mirror a register write, keeping only the register's own width.
  function void set_reg(logic [2:0] idx, logic [31:0] val);
    case (idx)
      REG_PULLED_UP:      pulled_up      = val[0];
      REG_NORMALLY_OPEN:  normally_open  = val[0];
      REG_DEBOUNCE_MS:    debounce_ms    = val[15:0];
      REG_START_DELAY_MS: start_delay_ms = val[15:0];
      REG_SERVICE_MS:     service_ms     = val[23:0];
      REG_WARNING_PCT:    warning_pct    = val[6:0];
      REG_RETRIGGERABLE:  retriggerable  = val[0];
      REG_KEEP_PILOT:     keep_pilot     = val[0];
      default: ;
    endcase
  endfunction

  // Advance the button by one accepted tick and queue the word it yields.
  function void note_tick(bit pin);
    bit [23:0] srv_eff;
    bit [15:0] deb_eff;
    bit [6:0]  pct_eff;
    bit [16:0] press_limit;
    bit [63:0] lead_prod;
    bit [23:0] lead;
    bit        changed;
    bit        warn_now;
    bit        pilot_now;
    res_t      word;

    srv_eff     = (service_ms < min_service) ? 24'(min_service) : service_ms;
    deb_eff     = (debounce_ms < min_debounce) ? 16'(min_debounce) : debounce_ms;
    pct_eff     = (warning_pct > PCT_MAX) ? PCT_MAX : warning_pct;
    press_limit = deb_eff + start_delay_ms;
    lead_prod   = srv_eff * pct_eff;
    lead        = 24'(lead_prod / PCT_MAX);
    changed     = 1'b0;

    // Polarity: pressed when the pin differs from its idle level.
    pressed_flag = ((pin ^ pulled_up ^ normally_open) == 1'b0);

    // Press timing gives at most one valid press per press.
    if (pressed_flag) begin
      if (!release_wait) begin
        if (!press_timing) begin
          press_timing = 1'b1;
          press_count  = '0;
        end else begin
          if (press_count != PRESS_MAX) press_count++;
          if (press_count >= press_limit) begin
            valid_press  = 1'b1;
            release_wait = 1'b1;
          end
        end
      end
    end else begin
      press_timing = 1'b0;
      press_count  = '0;
      release_wait = 1'b0;
    end

    // Service timer runs while on; expiry cancels a pending press.
    if (output_on) begin
      if (service_count != SERVICE_MAX) service_count++;
      if (service_count >= srv_eff) begin
        unlatch_wait = 1'b1;
        valid_press  = 1'b0;
      end
    end

    // Output latch.
    if (valid_press) begin
      if (!output_on) begin
        service_count = '0;
        output_on     = 1'b1;
        changed       = 1'b1;
        switch_ons++;
      end else if (retriggerable) begin
        service_count = '0;
      end
      valid_press = 1'b0;
    end else if (unlatch_wait && output_on) begin
      output_on    = 1'b0;
      unlatch_wait = 1'b0;
      changed      = 1'b1;
      expiries++;
    end

    // The warning flag holds its value while the warning share is zero.
    if (pct_eff != 0) begin
      warn_now = output_on && (service_count >= srv_eff - lead);
      if (warn_now != warning_flag) begin
        warning_flag = warn_now;
        changed      = 1'b1;
        if (warn_now) warning_rises++;
      end
    end

    pilot_now = keep_pilot && !output_on;
    if (pilot_now != pilot_flag) begin
      pilot_flag = pilot_now;
      changed    = 1'b1;
    end

    word.is_on           = output_on;
    word.warning_on      = warning_flag;
    word.pilot_on        = pilot_flag;
    word.is_pressed      = pressed_flag;
    word.outputs_changed = changed;
    result_q.push_back(word);
  endfunction

  function void compare_flag(string name, logic want, logic got);
    if (got !== want) begin
      $error("%s: expected %0b, got %0b", name, want, got);
      mismatches++;
    end
  endfunction

  // Check one accepted result word against the oldest expectation.
  function void check_result(res_t got);
    res_t want;
    if (result_q.size() == 0) begin
      $error("result word %b arrived with no tick outstanding", got);
      mismatches++;
      return;
    end
    want = result_q.pop_front();
    results_seen++;
    compare_flag("is_on", want.is_on, got.is_on);
    compare_flag("warning_on", want.warning_on, got.warning_on);
    compare_flag("pilot_on", want.pilot_on, got.pilot_on);
    compare_flag("is_pressed", want.is_pressed, got.is_pressed);
    compare_flag("outputs_changed", want.outputs_changed, got.outputs_changed);
  endfunction
endclass

module tb_timed_latch_button_with_warning;
  import tlbw_pkg::*;

  localparam int MIN_DEBOUNCE_MS  = 20;
  localparam int MIN_SERVICE_MS   = 1000;
  localparam int HOLD_OFF_CYCLES  = 64;
  localparam int NUM_PHASES       = 8;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  button_scoreboard sb;
  bit          steady;
  bit          hold_off_req;
  bit          press_pin;
  bit          slow_settings;
  int          press_limit;
  int          ticks_sent;
  int          input_stalls;
  int          settings_count;

  timed_latch_button_with_warning #(
    .MIN_DEBOUNCE_MS(MIN_DEBOUNCE_MS),
    .MIN_SERVICE_MS (MIN_SERVICE_MS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Idle length: mostly none, sometimes short, rarely long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Register value with random junk above the register's width now and then.
  function automatic logic [31:0] with_junk(logic [31:0] val, int width);
    logic [31:0] junk;
    junk = ($urandom_range(0, 2) == 0) ? $urandom : 32'd0;
    return val | (junk << width);
  endfunction

  // Offer one tick word and wait until it is taken.
  task automatic send_tick(bit pin);
    int gap;
    gap = steady ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {7'd0, pin};
    @(posedge clk);
    while (!s_tready) begin
      input_stalls++;
      @(posedge clk);
    end
    sb.note_tick(pin);
    ticks_sent++;
  endtask

  // Register write: setup cycle, then access cycle.
  task automatic apb_write(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = {idx, 2'b00};
    pwdata  = val;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_reg(idx, val);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Stop offering ticks and wait until every result word is back.
  task automatic wait_idle();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (sb.result_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic apply_settings(bit pu, bit no, bit [15:0] deb, bit [15:0] sd,
                                bit [23:0] srv, bit [6:0] pct, bit rt, bit kp);
    apb_write(REG_PULLED_UP, with_junk(32'(pu), 1));
    apb_write(REG_NORMALLY_OPEN, with_junk(32'(no), 1));
    apb_write(REG_DEBOUNCE_MS, with_junk(32'(deb), 16));
    apb_write(REG_START_DELAY_MS, with_junk(32'(sd), 16));
    apb_write(REG_SERVICE_MS, with_junk(32'(srv), 24));
    apb_write(REG_WARNING_PCT, with_junk(32'(pct), 7));
    apb_write(REG_RETRIGGERABLE, with_junk(32'(rt), 1));
    apb_write(REG_KEEP_PILOT, with_junk(32'(kp), 1));
    press_pin     = pu ^ no;
    press_limit   = ((deb < MIN_DEBOUNCE_MS) ? MIN_DEBOUNCE_MS : deb) + sd;
    slow_settings = (press_limit > 2000) || (srv > 2500);
    settings_count++;
  endtask

  // Press and release sequences with random lengths, plus bounce noise.
  task automatic run_phase(int n_ticks);
    int done;
    int len;
    int r;
    done = 0;
    while (done < n_ticks) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        r = $urandom_range(0, 99);
        if (r < 55) len = press_limit + $urandom_range(1, 30);
        else if (r < 80) len = $urandom_range(1, press_limit + 1);
        else len = $urandom_range(press_limit, press_limit + 300);
        if (len > n_ticks - done) len = n_ticks - done;
        repeat (len) send_tick(press_pin);
        done += len;
        r = $urandom_range(0, 99);
        if (r < 70) len = $urandom_range(1, 40);
        else if (r < 90) len = $urandom_range(41, 300);
        else len = $urandom_range(500, 1300);
        if (len > n_ticks - done) len = n_ticks - done;
        repeat (len) send_tick(!press_pin);
        done += len;
      end else begin
        len = $urandom_range(1, 12);
        repeat (len) send_tick(1'($urandom_range(0, 1)));
        done += len;
      end
    end
  endtask

  // Result side: random stalls, and a long hold-off whenever one is asked for.
  initial begin : result_sink
    int stall_left;
    int gap;
    m_tready   = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (rst) begin
        m_tready = 1'b0;
      end else if (stall_left > 0) begin
        m_tready = 1'b0;
        stall_left--;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_tready     = 1'b0;
        stall_left   = HOLD_OFF_CYCLES - 1;
      end else begin
        gap = steady ? 0 : pick_gap();
        m_tready   = (gap == 0);
        stall_left = (gap > 0) ? gap - 1 : 0;
      end
      @(posedge clk);
      if (m_tvalid && m_tready) sb.check_result(res_t'(m_tdata[4:0]));
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("Run timed out with %0d result words outstanding.", sb.result_q.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Main sequence: reset, directed ticks, then phases of fixed and random settings.
  initial begin : main_seq
    int phase_len;
    int r;
    bit [15:0] deb;
    bit [15:0] sd;
    bit [23:0] srv;
    bit [6:0]  pct;

    sb       = new(MIN_DEBOUNCE_MS, MIN_SERVICE_MS);
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    steady   = 1'b1;
    hold_off_req = 1'b0;
    press_pin    = 1'b0;
    press_limit  = MIN_DEBOUNCE_MS;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset settings: idle high, a press held just past the debounce time.
    repeat (2) send_tick(1'b1);
    repeat (22) send_tick(1'b0);
    send_tick(1'b1);

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      case (p)
        // Warning over the whole on time, retrigger and pilot enabled.
        0: apply_settings(1'b0, 1'b1, 16'd0, 16'd0, 24'd0, 7'd100, 1'b1, 1'b1);
        // Largest times and a percent above one hundred.
        1: apply_settings(1'b1, 1'b0, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 7'h7F,
                          1'b0, 1'b0);
        // Warning disabled: the flag keeps whatever value it had.
        2: apply_settings(1'b0, 1'b0, 16'd20, 16'd0, 24'd1000, 7'd0, 1'b0, 1'b1);
        // Debounce sum that needs the seventeenth bit.
        3: apply_settings(1'b1, 1'b1, 16'hFFFF, 16'd1, 24'd1500, 7'd1, 1'b1, 1'b0);
        default: begin
          r = $urandom_range(0, 99);
          deb = (r < 70) ? 16'($urandom_range(0, 40)) :
                (r < 90) ? 16'($urandom_range(41, 200)) :
                           16'($urandom_range(65000, 65535));
          r = $urandom_range(0, 99);
          sd = (r < 75) ? 16'($urandom_range(0, 10)) :
               (r < 90) ? 16'($urandom_range(11, 100)) :
                          16'($urandom_range(60000, 65535));
          r = $urandom_range(0, 99);
          srv = (r < 50) ? 24'($urandom_range(0, 1000)) :
                (r < 90) ? 24'($urandom_range(1001, 2500)) :
                           24'($urandom_range(16000000, 16777215));
          r = $urandom_range(0, 99);
          pct = (r < 25) ? 7'd0 :
                (r < 75) ? 7'($urandom_range(1, 99)) :
                (r < 85) ? 7'd100 : 7'($urandom_range(101, 127));
          apply_settings(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), deb, sd,
                         srv, pct, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
      endcase
      steady = (p == 0) || ($urandom_range(0, 3) == 0);
      if (p == 0 || $urandom_range(0, 2) == 0) hold_off_req = 1'b1;
      phase_len = slow_settings ? $urandom_range(90, 130) : $urandom_range(120, 150);
      run_phase(phase_len);
    end

    // Drain the remaining words, then allow a few more cycles for strays.
    @(negedge clk);
    s_tvalid = 1'b0;
    while (sb.result_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Run covered %0d ticks under %0d register settings, %0d switch-ons,",
             ticks_sent, settings_count + 1, sb.switch_ons);
    $display("%0d timer expiries, %0d warning rises and %0d cycles of input back-pressure.",
             sb.expiries, sb.warning_rises, input_stalls);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/tlbw_pkg.sv
rtl/tlbw_cfg.sv
rtl/tlbw_core.sv
rtl/tlbw_obuf.sv
rtl/timed_latch_button_with_warning.sv
rtl/tlbw_check.sv
test/tb_timed_latch_button_with_warning.sv
